// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/irpwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpwd_pkg
// Types, constants and check functions shared by the infrared pulse width decoder.
// ----------------------------------------------------------------------------
package irpwd_pkg;

   localparam int DUR_W     = 16;
   localparam int TOL_W     = 12;
   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 32;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_START_LOW   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_HIGH  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_HIGH = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_LOW    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_LOW     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_HIGH   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_HIGH    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE   = 4'd7;

   typedef struct packed {
      logic [DUR_W-1:0] start_low_width;
      logic [DUR_W-1:0] start_high_width;
      logic [DUR_W-1:0] repeat_high_width;
      logic [DUR_W-1:0] zero_low_width;
      logic [DUR_W-1:0] one_low_width;
      logic [DUR_W-1:0] zero_high_width;
      logic [DUR_W-1:0] one_high_width;
      logic [TOL_W-1:0] width_tolerance;
   } cfg_type;

   typedef struct packed {
      logic              emit;
      logic [BYTE_W-1:0] address_byte;
      logic [BYTE_W-1:0] command_byte;
      logic              is_repeat;
   } result_type;

   function automatic logic in_window(input logic [DUR_W-1:0] dur,
                                      input logic [DUR_W-1:0] nominal,
                                      input logic [TOL_W-1:0] tol);
      logic [DUR_W:0] dur_hi;
      logic [DUR_W:0] nom_hi;
      dur_hi = {1'b0, dur} + {{(DUR_W-TOL_W+1){1'b0}}, tol};
      nom_hi = {1'b0, nominal} + {{(DUR_W-TOL_W+1){1'b0}}, tol};
      return (dur_hi >= {1'b0, nominal}) && ({1'b0, dur} <= nom_hi);
   endfunction

   function automatic logic pair_ok(input logic [BYTE_W-1:0] a,
                                    input logic [BYTE_W-1:0] b);
      return (a == ~b) || (a == b);
   endfunction

endpackage

// ===== hdl/ir_pulse_width_decoder_top.sv =====
`timescale 1ns / 1ps
// An item taken on req passes the input register, then the result register, to rsp.
// Throughput: one item per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset: synchronous, active high; clears state, valids and loads default widths.
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder_top
// Infrared remote frame decoder working on timed edge items.
// ----------------------------------------------------------------------------
module ir_pulse_width_decoder_top #(
   parameter int FRAME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [0] line_level, [16:1] elapsed_us, [23:17] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] address_byte, [15:8] command_byte
   output logic [0:0]  rsp_tuser,   // [0] is_repeat
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_data
);

   irpwd_pkg::cfg_type    cfg;
   irpwd_pkg::result_type result;

   logic                        in_valid_ff;
   logic                        line_level_ff;
   logic [irpwd_pkg::DUR_W-1:0] elapsed_us_ff;
   logic                        rsp_valid_ff;
   logic [15:0]                 rsp_data_ff;
   logic                        rsp_repeat_ff;
   logic                        out_free;
   logic                        fire;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_repeat_ff;

   irpwd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   irpwd_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .line_level (line_level_ff),
      .elapsed_us (elapsed_us_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         line_level_ff <= req_tdata[0];
         elapsed_us_ff <= req_tdata[16:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire && result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.emit) begin
         rsp_data_ff   <= {result.command_byte, result.address_byte};
         rsp_repeat_ff <= result.is_repeat;
      end
   end

endmodule

// ===== hdl/irpwd_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpwd_csr
// Nominal width and tolerance registers with their write port.
// ----------------------------------------------------------------------------
module irpwd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [irpwd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [irpwd_pkg::DUR_W-1:0]         csr_data,
   output irpwd_pkg::cfg_type                  cfg
);

   irpwd_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_width   <= 16'd9000;
         cfg_ff.start_high_width  <= 16'd4500;
         cfg_ff.repeat_high_width <= 16'd2250;
         cfg_ff.zero_low_width    <= 16'd560;
         cfg_ff.one_low_width     <= 16'd560;
         cfg_ff.zero_high_width   <= 16'd560;
         cfg_ff.one_high_width    <= 16'd1690;
         cfg_ff.width_tolerance   <= 12'd200;
      end else if (csr_valid) begin
         unique case (csr_index)
            irpwd_pkg::REG_START_LOW:   cfg_ff.start_low_width   <= csr_data;
            irpwd_pkg::REG_START_HIGH:  cfg_ff.start_high_width  <= csr_data;
            irpwd_pkg::REG_REPEAT_HIGH: cfg_ff.repeat_high_width <= csr_data;
            irpwd_pkg::REG_ZERO_LOW:    cfg_ff.zero_low_width    <= csr_data;
            irpwd_pkg::REG_ONE_LOW:     cfg_ff.one_low_width     <= csr_data;
            irpwd_pkg::REG_ZERO_HIGH:   cfg_ff.zero_high_width   <= csr_data;
            irpwd_pkg::REG_ONE_HIGH:    cfg_ff.one_high_width    <= csr_data;
            irpwd_pkg::REG_TOLERANCE:
               cfg_ff.width_tolerance <= csr_data[irpwd_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ===== hdl/irpwd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpwd_core
// Frame state machine: window checks, bit assembly and frame validation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irpwd_core #(
   parameter int FRAME_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic                        line_level,
   input  logic [irpwd_pkg::DUR_W-1:0] elapsed_us,
   input  irpwd_pkg::cfg_type          cfg,
   output irpwd_pkg::result_type       result
);

   localparam int CNT_W = $clog2(FRAME_BITS + 1);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_START = 2'd1;
   localparam logic [1:0] PH_DATA  = 2'd2;

   localparam logic [irpwd_pkg::WORD_W-1:0] TOP_BIT =
      {1'b1, {(irpwd_pkg::WORD_W-1){1'b0}}};

   logic [1:0]                       phase_ff, phase_in;
   logic [CNT_W-1:0]                 bit_count_ff, bit_count_in;
   logic [irpwd_pkg::WORD_W-1:0]     frame_bits_ff, frame_bits_in;

   logic [CNT_W-1:0]                 count_inc;
   logic [irpwd_pkg::WORD_W-1:0]     frame_set;
   logic [irpwd_pkg::WORD_W-1:0]     frame_new;
   logic                             hit_start_low, hit_start_high, hit_repeat;
   logic                             hit_zero_low, hit_one_low;
   logic                             hit_zero_high, hit_one_high;
   logic                             frame_ok;

   assign hit_start_low  = irpwd_pkg::in_window(elapsed_us, cfg.start_low_width,
                                                cfg.width_tolerance);
   assign hit_start_high = irpwd_pkg::in_window(elapsed_us, cfg.start_high_width,
                                                cfg.width_tolerance);
   assign hit_repeat     = irpwd_pkg::in_window(elapsed_us, cfg.repeat_high_width,
                                                cfg.width_tolerance);
   assign hit_zero_low   = irpwd_pkg::in_window(elapsed_us, cfg.zero_low_width,
                                                cfg.width_tolerance);
   assign hit_one_low    = irpwd_pkg::in_window(elapsed_us, cfg.one_low_width,
                                                cfg.width_tolerance);
   assign hit_zero_high  = irpwd_pkg::in_window(elapsed_us, cfg.zero_high_width,
                                                cfg.width_tolerance);
   assign hit_one_high   = irpwd_pkg::in_window(elapsed_us, cfg.one_high_width,
                                                cfg.width_tolerance);

   assign count_inc = bit_count_ff + CNT_W'(1);
   assign frame_set = frame_bits_ff | (TOP_BIT >> bit_count_ff);
   assign frame_new = hit_zero_high ? frame_bits_ff : frame_set;
   assign frame_ok  = irpwd_pkg::pair_ok(frame_new[15:8], frame_new[7:0]) &&
                      irpwd_pkg::pair_ok(frame_new[31:24], frame_new[23:16]);

   always_comb begin
      phase_in            = phase_ff;
      bit_count_in        = bit_count_ff;
      frame_bits_in       = frame_bits_ff;
      result.emit         = 1'b0;
      result.is_repeat    = 1'b0;
      result.address_byte = frame_bits_ff[31:24];
      result.command_byte = frame_bits_ff[15:8];
      unique case (phase_ff)
         PH_START: begin
            if (line_level) begin
               if (!hit_start_low) phase_in = PH_IDLE;
            end else if (hit_start_high) begin
               phase_in      = PH_DATA;
               bit_count_in  = '0;
               frame_bits_in = '0;
            end else if (hit_repeat) begin
               result.emit      = 1'b1;
               result.is_repeat = 1'b1;
               phase_in         = PH_IDLE;
            end
         end
         PH_DATA: begin
            if (line_level) begin
               if (!hit_zero_low && !hit_one_low) phase_in = PH_IDLE;
            end else if (hit_zero_high || hit_one_high) begin
               frame_bits_in = frame_new;
               bit_count_in  = count_inc;
               if (count_inc == CNT_W'(FRAME_BITS)) begin
                  phase_in            = PH_IDLE;
                  result.emit         = frame_ok;
                  result.address_byte = frame_new[31:24];
                  result.command_byte = frame_new[15:8];
               end
            end else begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = line_level ? PH_IDLE : PH_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         frame_bits_ff <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         frame_bits_ff <= frame_bits_in;
      end
   end

   `ASSERT_IMP(a_count_in_range, clock, reset, 1'b1, bit_count_ff <= CNT_W'(FRAME_BITS))
   `ASSERT_IMP(a_frame_from_data, clock, reset, result.emit && !result.is_repeat,
               phase_ff == PH_DATA && count_inc == CNT_W'(FRAME_BITS))
   `ASSERT_IMP(a_repeat_from_start, clock, reset, result.emit && result.is_repeat,
               phase_ff == PH_START)
   `ASSERT_NXT(a_idle_after_emit, clock, reset, fire && result.emit, phase_ff == PH_IDLE)

endmodule
